// ===== rtl/met_pkg.sv =====
`default_nettype none

package met_pkg;

  // Item actions carried in the input tuser field.
  localparam logic [1:0] ACT_SAMPLE   = 2'd0;
  localparam logic [1:0] ACT_BASELINE = 2'd1;
  localparam logic [1:0] ACT_ROLLOVER = 2'd2;

  // Threshold modes, control bits 2:1.
  localparam logic [1:0] MODE_ABS  = 2'd0;
  localparam logic [1:0] MODE_BASE = 2'd1;
  localparam logic [1:0] MODE_RATE = 2'd2;

  // Decision rules, control bits 4:3.
  localparam logic [1:0] DEC_OR   = 2'd0;
  localparam logic [1:0] DEC_AND  = 2'd1;
  localparam logic [1:0] DEC_NOFM = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_CONTROL   = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_MASK      = 3'd2;
  localparam logic [2:0] REG_DURATION  = 3'd3;
  localparam logic [2:0] REG_DEAD      = 3'd4;
  localparam logic [2:0] REG_PRE       = 3'd5;
  localparam logic [2:0] REG_POST      = 3'd6;

  localparam int unsigned InChannels = 6;
  localparam int unsigned SampleW    = 32;
  localparam int unsigned IndexW     = 32;
  localparam int unsigned CountW     = 16;
  localparam int unsigned NumW       = 3;
  localparam int unsigned AddrW      = 5;

  localparam logic [CountW-1:0]     DETECT_MAX = 16'hFFFF;
  localparam logic [InChannels-1:0] MASK_RESET = 6'h3F;

  typedef struct packed {
    logic                  enable;
    logic [1:0]            mode;
    logic [1:0]            decision;
    logic [NumW-1:0]       n_needed;
    logic [15:0]           threshold;
    logic [InChannels-1:0] channel_mask;
    logic [15:0]           duration;
    logic [15:0]           dead;
    logic [15:0]           pre;
    logic [15:0]           post;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/multichannel_event_trigger_unit.sv =====
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tuser: action; tdata: index, ch0..ch5
// m_axis    out  m_axis_tvalid/tready         tuser: fired; tdata: trigger result
// apb       in   psel/penable/pwrite, pready  7 registers at byte address 4*i
//
// Every beat passes through the input register and then through the trigger
// logic into the result register.
// The block sustains one beat per cycle while the result is not stalled; the
// limit is the update of the trigger state between the two registers.
// Reset restores the register defaults and clears the tracking state, though
// not the stored samples. A stalled result holds the result register, and the
// input register then fills; s_axis_tready drops only when both are occupied.

module multichannel_event_trigger_unit #(
  parameter int unsigned CHANNELS = 6
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,

  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: sample_index[31:0], ch0_sample .. ch5_sample (32 each)
  input  wire logic [223:0] s_axis_tdata,
  // tuser: action[1:0]
  input  wire logic [1:0]   s_axis_tuser,

  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0: trigger_index[31:0], window_start[63:32],
  // window_end[95:64], fired_channels[101:96], event_sequence[133:102],
  // detected_count[149:134], zero pad[151:150]
  output logic [151:0]      m_axis_tdata,
  // tuser: fired[0]
  output logic              m_axis_tuser,

  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  // Channels beyond the six input fields always read as zero and can never
  // be watched, so only the lower lanes get hardware.
  localparam int unsigned NumLanes =
    (CHANNELS < met_pkg::InChannels) ? CHANNELS : met_pkg::InChannels;
  localparam int unsigned SW = met_pkg::SampleW;
  localparam int unsigned IW = met_pkg::IndexW;
  localparam int unsigned CW = met_pkg::CountW;

  met_pkg::cfg_t cfg;

  met_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic          a_valid_q;
  logic [1:0]    a_action_q;
  logic [IW-1:0] a_idx_q;
  logic [SW-1:0] a_ch_q [NumLanes];

  logic o_valid_q;
  logic o_load;
  logic in_fire;

  // The result register takes a new beat whenever it is empty or drained.
  assign o_load        = a_valid_q & (~o_valid_q | m_axis_tready);
  assign s_axis_tready = ~a_valid_q | o_load;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_action_q <= s_axis_tuser;
      a_idx_q    <= s_axis_tdata[IW-1:0];
      for (int l = 0; l < NumLanes; l++) begin
        a_ch_q[l] <= s_axis_tdata[IW + SW*l +: SW];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tracking state
  // ---------------------------------------------------------------------
  logic [SW-1:0] prev_q [NumLanes];
  logic [SW-1:0] base_q [NumLanes];
  logic          have_prev_q, have_prev_d;
  logic          have_base_q, have_base_d;
  logic          over_active_q, over_active_d;
  logic [IW-1:0] onset_q, onset_d;
  logic [IW-1:0] dead_until_q, dead_until_d;
  logic [IW-1:0] seq_q, seq_d;
  logic [CW-1:0] det_q, det_d;
  logic          take_prev;
  logic          take_base;

  // Per-channel threshold tests run in parallel.
  logic [NumLanes-1:0] over_lane;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    met_chan u_chan (
      .sample_i    (a_ch_q[l]),
      .base_i      (base_q[l]),
      .prev_i      (prev_q[l]),
      .have_base_i (have_base_q),
      .have_prev_i (have_prev_q),
      .mode_i      (cfg.mode),
      .threshold_i (cfg.threshold),
      .watch_i     (cfg.channel_mask[l]),
      .over_o      (over_lane[l])
    );
  end

  // ---------------------------------------------------------------------
  // Decision and trigger
  // ---------------------------------------------------------------------
  logic [met_pkg::InChannels-1:0] over_mask;
  logic [met_pkg::InChannels-1:0] watch_mask;
  logic [met_pkg::NumW-1:0]       n_over;
  logic                           cond;
  logic                           in_dead;
  logic [IW-1:0]                  trig;
  logic [IW-1:0]                  elapsed;
  logic                           long_enough;
  logic [IW-1:0]                  win_start;
  logic [IW-1:0]                  win_end;
  logic                           fire;

  always_comb begin
    over_mask  = '0;
    watch_mask = '0;
    n_over     = '0;
    for (int l = 0; l < NumLanes; l++) begin
      over_mask[l]  = over_lane[l];
      watch_mask[l] = cfg.channel_mask[l];
      n_over        = n_over + met_pkg::NumW'(over_lane[l]);
    end
  end

  always_comb begin
    cond = 1'b0;
    case (cfg.decision)
      met_pkg::DEC_OR:   cond = |over_mask;
      // An empty watch set never satisfies the AND rule.
      met_pkg::DEC_AND:  cond = (|watch_mask) & (over_mask == watch_mask);
      met_pkg::DEC_NOFM: cond = (n_over >= cfg.n_needed);
      default:           cond = 1'b0;
    endcase
  end

  // The onset is this sample unless a run of true conditions is already
  // under way, so the elapsed count and the window do not wait for cond.
  assign in_dead     = a_idx_q < dead_until_q;
  assign trig        = over_active_q ? onset_q : a_idx_q;
  assign elapsed     = over_active_q ? (a_idx_q - onset_q) : '0;
  assign long_enough = elapsed >= {16'd0, cfg.duration};
  assign win_start   = (trig > {16'd0, cfg.pre}) ? (trig - {16'd0, cfg.pre}) : '0;
  assign win_end     = trig + {16'd0, cfg.post};

  always_comb begin
    have_prev_d   = have_prev_q;
    have_base_d   = have_base_q;
    over_active_d = over_active_q;
    onset_d       = onset_q;
    dead_until_d  = dead_until_q;
    seq_d         = seq_q;
    det_d         = det_q;
    take_prev     = 1'b0;
    take_base     = 1'b0;
    fire          = 1'b0;
    case (a_action_q)
      met_pkg::ACT_SAMPLE: begin
        // The previous sample is refreshed even while disabled or dead.
        take_prev   = 1'b1;
        have_prev_d = 1'b1;
        if (!cfg.enable || in_dead || !cond) begin
          over_active_d = 1'b0;
        end else if (long_enough) begin
          fire          = 1'b1;
          over_active_d = 1'b0;
          seq_d         = seq_q + 1'b1;
          dead_until_d  = a_idx_q + {16'd0, cfg.dead};
          if (det_q != met_pkg::DETECT_MAX) begin
            det_d = det_q + 1'b1;
          end
        end else begin
          over_active_d = 1'b1;
          onset_d       = trig;
        end
      end
      met_pkg::ACT_BASELINE: begin
        take_base   = 1'b1;
        have_base_d = 1'b1;
      end
      met_pkg::ACT_ROLLOVER: begin
        det_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q   <= 1'b0;
      have_base_q   <= 1'b0;
      over_active_q <= 1'b0;
      onset_q       <= '0;
      dead_until_q  <= '0;
      seq_q         <= '0;
      det_q         <= '0;
    end else if (o_load) begin
      have_prev_q   <= have_prev_d;
      have_base_q   <= have_base_d;
      over_active_q <= over_active_d;
      onset_q       <= onset_d;
      dead_until_q  <= dead_until_d;
      seq_q         <= seq_d;
      det_q         <= det_d;
    end
  end

  // Stored samples are only read once their valid flag is set.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NumLanes; l++) begin
      if (o_load && take_prev) prev_q[l] <= a_ch_q[l];
      if (o_load && take_base) base_q[l] <= a_ch_q[l];
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic                           r_fired_q;
  logic [IW-1:0]                  r_trig_q;
  logic [IW-1:0]                  r_start_q;
  logic [IW-1:0]                  r_end_q;
  logic [met_pkg::InChannels-1:0] r_chans_q;
  logic [IW-1:0]                  r_seq_q;
  logic [CW-1:0]                  r_det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_load) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  // Fields other than the detection count read as zero when nothing fired.
  always_ff @(posedge clk_i) begin
    if (o_load) begin
      r_fired_q <= fire;
      r_trig_q  <= fire ? trig      : '0;
      r_start_q <= fire ? win_start : '0;
      r_end_q   <= fire ? win_end   : '0;
      r_chans_q <= fire ? over_mask : '0;
      r_seq_q   <= fire ? seq_q     : '0;
      r_det_q   <= det_d;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = r_fired_q;
  assign m_axis_tdata  = {2'b00, r_det_q, r_seq_q, r_chans_q, r_end_q, r_start_q, r_trig_q};

endmodule

`default_nettype wire

// ===== rtl/met_regs.sv =====
`default_nettype none

// Configuration register file behind a simple APB slave.
module met_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [met_pkg::AddrW-1:0]   paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output met_pkg::cfg_t                    cfg_o
);

  met_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[met_pkg::AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // Everything resets to zero except the channel mask, which watches all
      // channels: 24 bits of control and threshold above it, 64 bits of
      // duration, dead, pre and post below it.
      cfg_q <= met_pkg::cfg_t'({24'd0, met_pkg::MASK_RESET, 64'd0});
    end else if (wr_en) begin
      case (reg_idx)
        met_pkg::REG_CONTROL: begin
          cfg_q.enable   <= pwdata[0];
          cfg_q.mode     <= pwdata[2:1];
          cfg_q.decision <= pwdata[4:3];
          cfg_q.n_needed <= pwdata[7:5];
        end
        met_pkg::REG_THRESHOLD: cfg_q.threshold    <= pwdata[15:0];
        met_pkg::REG_MASK:      cfg_q.channel_mask <= pwdata[met_pkg::InChannels-1:0];
        met_pkg::REG_DURATION:  cfg_q.duration     <= pwdata[15:0];
        met_pkg::REG_DEAD:      cfg_q.dead         <= pwdata[15:0];
        met_pkg::REG_PRE:       cfg_q.pre          <= pwdata[15:0];
        met_pkg::REG_POST:      cfg_q.post         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      met_pkg::REG_CONTROL:
        prdata = {24'd0, cfg_q.n_needed, cfg_q.decision, cfg_q.mode, cfg_q.enable};
      met_pkg::REG_THRESHOLD: prdata = {16'd0, cfg_q.threshold};
      met_pkg::REG_MASK:      prdata = {26'd0, cfg_q.channel_mask};
      met_pkg::REG_DURATION:  prdata = {16'd0, cfg_q.duration};
      met_pkg::REG_DEAD:      prdata = {16'd0, cfg_q.dead};
      met_pkg::REG_PRE:       prdata = {16'd0, cfg_q.pre};
      met_pkg::REG_POST:      prdata = {16'd0, cfg_q.post};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/met_chan.sv =====
`default_nettype none

// One channel's threshold test: absolute value, change from baseline or
// change from the previous sample, compared at 33 bits so nothing overflows.
module met_chan (
  input  wire logic [met_pkg::SampleW-1:0] sample_i,
  input  wire logic [met_pkg::SampleW-1:0] base_i,
  input  wire logic [met_pkg::SampleW-1:0] prev_i,
  input  wire logic                        have_base_i,
  input  wire logic                        have_prev_i,
  input  wire logic [1:0]                  mode_i,
  input  wire logic [15:0]                 threshold_i,
  input  wire logic                        watch_i,
  output logic                             over_o
);

  logic [met_pkg::SampleW-1:0] ref_val;
  logic                        ref_ok;
  logic [met_pkg::SampleW:0]   diff;
  logic [met_pkg::SampleW:0]   mag;

  always_comb begin
    ref_val = '0;
    ref_ok  = 1'b0;
    case (mode_i)
      met_pkg::MODE_ABS: begin
        ref_val = '0;
        ref_ok  = 1'b1;
      end
      met_pkg::MODE_BASE: begin
        ref_val = base_i;
        ref_ok  = have_base_i;
      end
      met_pkg::MODE_RATE: begin
        ref_val = prev_i;
        ref_ok  = have_prev_i;
      end
      default: begin
        ref_val = '0;
        ref_ok  = 1'b0;
      end
    endcase
  end

  assign diff   = {sample_i[met_pkg::SampleW-1], sample_i}
                - {ref_val[met_pkg::SampleW-1], ref_val};
  assign mag    = diff[met_pkg::SampleW] ? (~diff + 1'b1) : diff;
  assign over_o = watch_i & ref_ok & (mag >= {17'd0, threshold_i});

endmodule

`default_nettype wire

// ===== verif/multichannel_event_trigger_unit_test.sv =====
`timescale 1ns / 1ps

module multichannel_event_trigger_unit_test;

  // Codes the package leaves out: the ignored action, the mode that sees no
  // channel over threshold, and the decision that never holds.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam logic [1:0] DEC_NEVER  = 2'd3;

  localparam int RANDOM_BEATS  = 430;
  localparam int FIRE_BEATS    = 40;
  localparam int HOLD_CYCLES   = 64;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 2000;

  // One input beat: the action in tuser, the index and six channels in tdata.
  typedef struct packed {
    logic [1:0]       action;
    logic [31:0]      index;
    logic [5:0][31:0] ch;
  } sample_beat_t;

  // One output beat as it is expected.
  typedef struct packed {
    logic        fired;
    logic [31:0] trig;
    logic [31:0] wstart;
    logic [31:0] wend;
    logic [5:0]  chans;
    logic [31:0] seq;
    logic [15:0] count;
  } trigger_report_t;

  // Tracks the register settings and the trigger state of the block and keeps
  // the reports that accepted input beats are still owed.
  class trigger_scoreboard;
    met_pkg::cfg_t     cfg;
    logic [5:0][31:0]  last_sample;
    logic [5:0][31:0]  baseline;
    bit                have_last;
    bit                have_baseline;
    bit                armed;
    logic [31:0]       onset;
    logic [31:0]       dead_until;
    logic [31:0]       seq_next;
    logic [15:0]       detections;
    trigger_report_t   awaited_reports[$];
    int                mismatches;

    function new();
      cfg = '0;
      cfg.channel_mask = met_pkg::MASK_RESET;
      last_sample = '0;
      baseline = '0;
      have_last = 1'b0;
      have_baseline = 1'b0;
      armed = 1'b0;
      onset = '0;
      dead_until = '0;
      seq_next = '0;
      detections = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [31:0] value);
      case (index)
        met_pkg::REG_CONTROL:
          {cfg.n_needed, cfg.decision, cfg.mode, cfg.enable} = value[7:0];
        met_pkg::REG_THRESHOLD: cfg.threshold = value[15:0];
        met_pkg::REG_MASK:      cfg.channel_mask = value[5:0];
        met_pkg::REG_DURATION:  cfg.duration = value[15:0];
        met_pkg::REG_DEAD:      cfg.dead = value[15:0];
        met_pkg::REG_PRE:       cfg.pre = value[15:0];
        met_pkg::REG_POST:      cfg.post = value[15:0];
        default: ;
      endcase
    endfunction

    // Magnitudes are formed at 64 bits so that a change across the whole
    // signed range does not overflow.
    function bit channel_over(logic [31:0] cur, logic [31:0] older, logic [31:0] base,
                              bit older_ok);
      longint value;
      value = longint'($signed(cur));
      case (cfg.mode)
        met_pkg::MODE_ABS: ;
        met_pkg::MODE_BASE: begin
          if (!have_baseline) return 1'b0;
          value = value - longint'($signed(base));
        end
        met_pkg::MODE_RATE: begin
          if (!older_ok) return 1'b0;
          value = value - longint'($signed(older));
        end
        default: return 1'b0;
      endcase
      if (value < 0) value = -value;
      return value >= longint'(cfg.threshold);
    endfunction

    function void note_beat(sample_beat_t b);
      trigger_report_t  r;
      logic [5:0][31:0] older;
      bit               older_ok;
      logic [5:0]       over_mask;
      logic [31:0]      elapsed;
      int               n_over;
      int               n_watched;
      bit               cond;
      r = '0;
      case (b.action)
        met_pkg::ACT_BASELINE: begin
          baseline = b.ch;
          have_baseline = 1'b1;
        end
        met_pkg::ACT_ROLLOVER: detections = '0;
        met_pkg::ACT_SAMPLE: begin
          // The previous sample is refreshed even when disabled or dead.
          older = last_sample;
          older_ok = have_last;
          last_sample = b.ch;
          have_last = 1'b1;
          if (!cfg.enable || b.index < dead_until) begin
            armed = 1'b0;
          end else begin
            over_mask = '0;
            n_over = 0;
            n_watched = 0;
            for (int c = 0; c < 6; c++) begin
              if (cfg.channel_mask[c]) begin
                n_watched++;
                if (channel_over(b.ch[c], older[c], baseline[c], older_ok)) begin
                  over_mask[c] = 1'b1;
                  n_over++;
                end
              end
            end
            case (cfg.decision)
              met_pkg::DEC_OR:   cond = n_over >= 1;
              met_pkg::DEC_AND:  cond = n_watched > 0 && n_over == n_watched;
              met_pkg::DEC_NOFM: cond = n_over >= int'(cfg.n_needed);
              default:           cond = 1'b0;
            endcase
            if (!cond) begin
              armed = 1'b0;
            end else begin
              if (!armed) begin
                armed = 1'b1;
                onset = b.index;
              end
              elapsed = b.index - onset;
              if (elapsed >= {16'h0, cfg.duration}) begin
                r.fired = 1'b1;
                r.trig = onset;
                r.wstart = (onset > {16'h0, cfg.pre}) ? onset - {16'h0, cfg.pre} : '0;
                r.wend = onset + {16'h0, cfg.post};
                r.chans = over_mask;
                r.seq = seq_next;
                seq_next = seq_next + 32'd1;
                if (detections != met_pkg::DETECT_MAX) detections = detections + 16'd1;
                armed = 1'b0;
                dead_until = b.index + {16'h0, cfg.dead};
              end
            end
          end
        end
        default: ;
      endcase
      r.count = detections;
      awaited_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, expected, actual);
        mismatches++;
      end
    endfunction

    function void check_report(logic fired, logic [151:0] data);
      trigger_report_t e;
      if (awaited_reports.size() == 0) begin
        $display("%0t: result beat with nothing awaited, expected none actual %0b/%0h",
                 $time, fired, data);
        mismatches++;
        return;
      end
      e = awaited_reports.pop_front();
      compare_field("fired", 32'(e.fired), 32'(fired));
      compare_field("trigger_index", e.trig, data[31:0]);
      compare_field("window_start", e.wstart, data[63:32]);
      compare_field("window_end", e.wend, data[95:64]);
      compare_field("fired_channels", 32'(e.chans), 32'(data[101:96]));
      compare_field("event_sequence", e.seq, data[133:102]);
      compare_field("detected_count", 32'(e.count), 32'(data[149:134]));
      compare_field("pad", 32'd0, 32'(data[151:150]));
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = met_pkg::ACT_SAMPLE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Control of idling: quiet switches random idling off on both sides, and
  // hold_req asks the receiver for one long hold-off.
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  trigger_scoreboard board;

  // Stimulus state: the next running index, what the block last saw as a
  // sample and as a baseline, and how many more beats stay above threshold.
  logic [31:0]      next_index = '0;
  logic [5:0][31:0] gen_last = '0;
  logic [5:0][31:0] gen_base = '0;
  int               hot_left = 0;
  int               idle_cycles = 0;

  multichannel_event_trigger_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: checks every accepted result beat against the oldest awaited
  // report. It idles at random, except during the quiet stretch, and serves
  // one long hold-off on request, counted here so that the input side fills.
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_report(m_axis_tuser, m_axis_tdata);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either side means a hang.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("multichannel_event_trigger_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // A register write: setup cycle, then access cycle. The task returns at
  // the edge that writes the register, leaving psel and penable high so that
  // a following write can start in the same step.
  task automatic apb_write(logic [2:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.set_reg(index, value);
  endtask

  task automatic write_config(met_pkg::cfg_t cfg);
    apb_write(met_pkg::REG_CONTROL,
              {24'h0, cfg.n_needed, cfg.decision, cfg.mode, cfg.enable});
    apb_write(met_pkg::REG_THRESHOLD, {16'h0, cfg.threshold});
    apb_write(met_pkg::REG_MASK, {26'h0, cfg.channel_mask});
    apb_write(met_pkg::REG_DURATION, {16'h0, cfg.duration});
    apb_write(met_pkg::REG_DEAD, {16'h0, cfg.dead});
    apb_write(met_pkg::REG_PRE, {16'h0, cfg.pre});
    apb_write(met_pkg::REG_POST, {16'h0, cfg.post});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic met_pkg::cfg_t make_cfg(logic en, logic [1:0] mode, logic [1:0] dec,
                                             logic [2:0] n, logic [15:0] thr,
                                             logic [5:0] mask, logic [15:0] dur,
                                             logic [15:0] dead, logic [15:0] pre,
                                             logic [15:0] post);
    met_pkg::cfg_t cfg;
    cfg.enable = en;
    cfg.mode = mode;
    cfg.decision = dec;
    cfg.n_needed = n;
    cfg.threshold = thr;
    cfg.channel_mask = mask;
    cfg.duration = dur;
    cfg.dead = dead;
    cfg.pre = pre;
    cfg.post = post;
    return cfg;
  endfunction

  function automatic met_pkg::cfg_t random_cfg();
    met_pkg::cfg_t cfg;
    int            pick;
    cfg.enable = $urandom_range(99) < 90;
    cfg.mode = ($urandom_range(99) < 92) ? 2'($urandom_range(2)) : MODE_NONE;
    cfg.decision = ($urandom_range(99) < 92) ? 2'($urandom_range(2)) : DEC_NEVER;
    cfg.n_needed = 3'($urandom_range(7));
    case ($urandom_range(5))
      0:       cfg.threshold = '0;
      1:       cfg.threshold = 16'hFFFF;
      2, 3:    cfg.threshold = 16'($urandom_range(1000));
      default: cfg.threshold = 16'($urandom());
    endcase
    cfg.channel_mask = ($urandom_range(9) == 0) ? 6'h3F : 6'($urandom());
    pick = $urandom_range(9);
    cfg.duration = (pick < 8) ? 16'($urandom_range(4)) : (pick == 8) ? 16'hFFFF : 16'($urandom());
    pick = $urandom_range(19);
    cfg.dead = (pick < 15) ? 16'($urandom_range(6)) : (pick < 17) ? 16'hFFFF
             : 16'($urandom_range(200));
    pick = $urandom_range(3);
    cfg.pre = (pick < 2) ? 16'($urandom()) : (pick == 2) ? 16'hFFFF : 16'($urandom_range(10));
    pick = $urandom_range(3);
    cfg.post = (pick < 2) ? 16'($urandom()) : (pick == 2) ? 16'hFFFF : 16'($urandom_range(10));
    return cfg;
  endfunction

  function automatic sample_beat_t beat_of(logic [1:0] action, logic [31:0] index,
                                           logic [31:0] ch0, logic [31:0] others);
    sample_beat_t b;
    b.action = action;
    b.index = index;
    b.ch = {{5{others}}, ch0};
    return b;
  endfunction

  // Mostly samples at consecutive indexes. Runs of "hot" beats put most
  // channels just past the threshold, measured from whatever the current
  // mode compares against, so that the condition persists long enough to
  // get through the duration; the rest sits around or below the threshold,
  // with some full-range values mixed in.
  function automatic sample_beat_t random_beat();
    sample_beat_t b;
    logic [31:0]  thr;
    logic [31:0]  center;
    logic [31:0]  mag;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 4) b.action = met_pkg::ACT_BASELINE;
    else if (pick < 8) b.action = met_pkg::ACT_ROLLOVER;
    else if (pick < 12) b.action = ACT_UNUSED;
    else b.action = met_pkg::ACT_SAMPLE;
    pick = $urandom_range(99);
    if (pick < 88) b.index = next_index;
    else if (pick < 94) b.index = next_index + $urandom_range(100000);
    else if (pick < 97) b.index = $urandom();
    else b.index = next_index - 32'd1;
    next_index = b.index + 32'd1;
    if (hot_left > 0) hot_left--;
    else if ($urandom_range(99) < 30) hot_left = $urandom_range(8, 1);
    thr = {16'h0, board.cfg.threshold};
    for (int c = 0; c < 6; c++) begin
      case (board.cfg.mode)
        met_pkg::MODE_BASE: center = gen_base[c];
        met_pkg::MODE_RATE: center = gen_last[c];
        default:            center = '0;
      endcase
      pick = $urandom_range(99);
      if (pick < 8) begin
        b.ch[c] = $urandom();
      end else begin
        if ((hot_left > 0 && pick < 85) || pick < 20) mag = thr + $urandom_range(40);
        else if (pick < 92) mag = $urandom_range(thr / 2);
        else mag = thr + $urandom_range(2) - 32'd1;
        b.ch[c] = $urandom_range(1) ? center + mag : center - mag;
      end
    end
    return b;
  endfunction

  // Offers one beat, idling first at random, and waits for its acceptance.
  // The valid is left high on return; the next call either keeps it high or
  // drops it for an idle cycle, so it is assigned once per step.
  task automatic send_beat(sample_beat_t b);
    if (!quiet && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.ch, b.index};
    s_axis_tuser  <= b.action;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_beat(b);
    if (b.action == met_pkg::ACT_SAMPLE) gen_last = b.ch;
    if (b.action == met_pkg::ACT_BASELINE) gen_base = b.ch;
  endtask

  // Stops offering and waits until every awaited report has arrived, then
  // lets the two pipeline stages run empty before anything is reconfigured.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    met_pkg::cfg_t cfg;
    int            sent;
    int            phase;
    int            burst;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rate mode on the very first sample finds no previous sample, so even a
    // zero threshold sees nothing; the next sample fires on a zero change.
    write_config(make_cfg(1'b1, met_pkg::MODE_RATE, met_pkg::DEC_OR, 3'd0, 16'h0, 6'h3F,
                          16'd0, 16'd0, 16'd0, 16'd0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd0, 32'h8000_0000, 32'h8000_0000));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd1, 32'h8000_0000, 32'h8000_0000));
    send_beat(beat_of(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();

    // Baseline mode before any capture sees nothing; after the capture, a
    // swing across the whole signed range counts at full magnitude.
    write_config(make_cfg(1'b1, met_pkg::MODE_BASE, met_pkg::DEC_OR, 3'd0, 16'h0, 6'h3F,
                          16'd0, 16'd0, 16'd0, 16'd0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd2, 32'h0000_0001, 32'h0000_0001));
    send_beat(beat_of(met_pkg::ACT_BASELINE, 32'd3, 32'h7FFF_FFFF, 32'h1234_5678));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd4, 32'h8000_0000, 32'hEDCB_A987));
    send_beat(beat_of(met_pkg::ACT_ROLLOVER, 32'd4, 32'h0, 32'h0));
    drain();

    // Disabled: nothing fires even at a zero threshold.
    write_config(make_cfg(1'b0, met_pkg::MODE_ABS, met_pkg::DEC_OR, 3'd0, 16'h0, 6'h3F,
                          16'd0, 16'd0, 16'd0, 16'd0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    drain();

    // Largest threshold and windows: the window start floors at zero and the
    // window end wraps near the top of the index range.
    write_config(make_cfg(1'b1, met_pkg::MODE_ABS, met_pkg::DEC_OR, 3'd0, 16'hFFFF, 6'h3F,
                          16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd5, 32'h7FFF_FFFF, 32'h0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd6, 32'hFFFF_0001, 32'hFFFF_0001));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd7, 32'h0000_FFFE, 32'hFFFF_0002));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'hFFFF_FFF0, 32'h8000_0000, 32'h0));
    drain();

    // Rate mode with AND over channels 0 and 5: changes of nearly 2^32.
    write_config(make_cfg(1'b1, met_pkg::MODE_RATE, met_pkg::DEC_AND, 3'd0, 16'h8000, 6'h21,
                          16'd0, 16'd0, 16'd0, 16'd0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd10, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd11, 32'h8000_0000, 32'h8000_0000));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd12, 32'h8000_0000, 32'h8000_1000));
    drain();

    // AND with no watched channel never holds.
    write_config(make_cfg(1'b1, met_pkg::MODE_ABS, met_pkg::DEC_AND, 3'd0, 16'h0, 6'h00,
                          16'd0, 16'd0, 16'd0, 16'd0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd13, 32'h1, 32'h1));
    drain();

    // N-of-M with N zero always holds, even where no channel can be over.
    write_config(make_cfg(1'b1, MODE_NONE, met_pkg::DEC_NOFM, 3'd0, 16'h0, 6'h00,
                          16'd0, 16'd0, 16'd0, 16'd0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd14, 32'h1, 32'h1));
    drain();

    // Every control bit set: the fourth decision code never holds.
    write_config(make_cfg(1'b1, MODE_NONE, DEC_NEVER, 3'h7, 16'h0, 6'h3F,
                          16'd0, 16'd0, 16'd0, 16'd0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd15, 32'h1, 32'h1));
    drain();

    // Duration and dead time: a break in the condition moves the onset, the
    // trigger reports the onset, and the dead time suppresses what follows.
    write_config(make_cfg(1'b1, met_pkg::MODE_ABS, met_pkg::DEC_NOFM, 3'd3, 16'd100, 6'h3F,
                          16'd2, 16'd3, 16'd1, 16'd1));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd100, 32'd200, 32'd200));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd101, 32'd200, 32'd0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd102, 32'd200, 32'hFFFF_FF38));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd103, 32'd200, 32'd200));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd104, 32'd200, 32'd200));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd105, 32'd200, 32'd200));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, 32'd107, 32'd200, 32'd200));
    drain();

    // Random phases, each under a fresh setting. The first runs without any
    // idling and with one long receiver hold-off, so the input side stalls;
    // the next two force the longest duration and the longest dead time.
    sent = 0;
    phase = 0;
    next_index = $urandom();
    while (sent < RANDOM_BEATS) begin
      cfg = random_cfg();
      if (phase == 1) cfg.duration = 16'hFFFF;
      if (phase == 2) begin
        cfg.enable = 1'b1;
        cfg.duration = '0;
        cfg.dead = 16'hFFFF;
      end
      write_config(cfg);
      burst = $urandom_range(60, 25);
      if (phase == 0) begin
        quiet <= 1'b1;
        hold_req <= 1'b1;
        burst = 60;
      end
      for (int i = 0; i < burst; i++) send_beat(random_beat());
      sent += burst;
      drain();
      quiet <= 1'b0;
      phase++;
    end

    // Every sample fires under a zero threshold, each one counted; a
    // rollover afterwards clears the detection count again.
    write_config(make_cfg(1'b1, met_pkg::MODE_ABS, met_pkg::DEC_OR, 3'd0, 16'h0, 6'h3F,
                          16'd0, 16'd0, 16'($urandom()), 16'($urandom())));
    send_beat(beat_of(met_pkg::ACT_ROLLOVER, next_index, 32'h0, 32'h0));
    for (int i = 0; i < FIRE_BEATS; i++) begin
      send_beat(beat_of(met_pkg::ACT_SAMPLE, next_index, $urandom(), $urandom()));
      next_index = next_index + 32'd1;
    end
    send_beat(beat_of(met_pkg::ACT_ROLLOVER, next_index, 32'h0, 32'h0));
    send_beat(beat_of(met_pkg::ACT_SAMPLE, next_index, $urandom(), $urandom()));
    drain();

    if (board.mismatches == 0) begin
      $display("multichannel_event_trigger_unit: match");
    end else begin
      $display("multichannel_event_trigger_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== multichannel_event_trigger_unit.f =====
rtl/met_pkg.sv
rtl/met_regs.sv
rtl/met_chan.sv
rtl/multichannel_event_trigger_unit.sv
verif/multichannel_event_trigger_unit_test.sv
